>>> hdl/bbps_pkg.sv
// Shared types and constants for the buzzer beep pattern sequencer.
package bbps_pkg;

	localparam int DUR_W          = 16;
	localparam int COUNT_W        = 8;
	localparam int INPUT_SEGMENTS = 6;

	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_BEEPS   = 2'd1,
		MODE_PATTERN = 2'd2,
		MODE_LEVEL   = 2'd3
	} mode_t;

	typedef logic [DUR_W-1:0]   dur_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		mode_t  mode;
		dur_t   elapsed_ms;
		logic   drive_level;
		count_t repeat_count;
		dur_t   beep_on_ms;
		dur_t   beep_off_ms;
		dur_t   first_on_ms;
		dur_t   first_off_ms;
		dur_t   second_on_ms;
		dur_t   second_off_ms;
		dur_t   third_on_ms;
		dur_t   third_off_ms;
	} cmd_t;

	typedef struct packed {
		logic buzzer_on;
		logic busy_res;
	} rsp_t;

endpackage

>>> hdl/bbps_core.sv
// Sequencer state and per-transaction next-state logic.
module bbps_core import bbps_pkg::*; #(
	parameter int PATTERN_SEGMENTS = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  cmd_t item,
	output rsp_t res
);

	localparam int PH_W  = $clog2(PATTERN_SEGMENTS + 2);
	localparam int SEG_W = $clog2(PATTERN_SEGMENTS);

	typedef enum logic [1:0] {
		KIND_IDLE    = 2'd0,
		KIND_BEEPS   = 2'd1,
		KIND_PATTERN = 2'd2
	} kind_t;

	kind_t             kind_q, kind_d;
	logic [PH_W-1:0]   phase_q, phase_d;
	dur_t              cnt_q, cnt_d;
	count_t            beeps_q, beeps_d;
	dur_t              on_q, on_d;
	dur_t              off_q, off_d;
	logic              level_q, level_d;
	dur_t              seg_q [PATTERN_SEGMENTS];
	logic              seg_load;

	dur_t              in_seg [INPUT_SEGMENTS];
	dur_t              load_seg [PATTERN_SEGMENTS];
	dur_t              sum;
	logic [PH_W-1:0]   idx;

	assign in_seg[0] = item.first_on_ms;
	assign in_seg[1] = item.first_off_ms;
	assign in_seg[2] = item.second_on_ms;
	assign in_seg[3] = item.second_off_ms;
	assign in_seg[4] = item.third_on_ms;
	assign in_seg[5] = item.third_off_ms;

	// segments past the six inputs load as zero
	for (genvar g = 0; g < PATTERN_SEGMENTS; g++) begin : g_load
		if (g < INPUT_SEGMENTS) begin : g_in
			assign load_seg[g] = in_seg[g];
		end else begin : g_zero
			assign load_seg[g] = '0;
		end
	end

	assign sum = cnt_q + item.elapsed_ms;
	assign idx = phase_q - PH_W'(1);

	always_comb begin
		kind_d   = kind_q;
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		beeps_d  = beeps_q;
		on_d     = on_q;
		off_d    = off_q;
		level_d  = level_q;
		seg_load = 1'b0;
		case (item.mode)
			MODE_TICK: begin
				if (kind_q != KIND_IDLE) begin
					cnt_d = sum;
					case (kind_q)
						KIND_BEEPS: begin
							if (phase_q == '0) begin
								if (beeps_q == '0) begin
									kind_d  = KIND_IDLE;
									phase_d = '0;
									cnt_d   = '0;
									level_d = 1'b0;
								end else begin
									phase_d = PH_W'(1);
									level_d = 1'b1;
								end
							end else if (phase_q == PH_W'(1)) begin
								if (sum >= on_q) begin
									phase_d = PH_W'(2);
									cnt_d   = '0;
									level_d = 1'b0;
								end
							end else if (phase_q == PH_W'(2)) begin
								if (sum >= off_q) begin
									phase_d = '0;
									cnt_d   = '0;
									if (beeps_q != '0)
										beeps_d = beeps_q - COUNT_W'(1);
								end
							end else begin
								kind_d  = KIND_IDLE;
								phase_d = '0;
								cnt_d   = '0;
								level_d = 1'b0;
							end
						end
						KIND_PATTERN: begin
							if (phase_q == '0) begin
								phase_d = PH_W'(1);
								cnt_d   = '0;
								level_d = 1'b1;
							end else if (idx >= PH_W'(PATTERN_SEGMENTS)) begin
								kind_d  = KIND_IDLE;
								phase_d = '0;
								cnt_d   = '0;
								level_d = 1'b0;
							end else if (sum >= seg_q[idx[SEG_W-1:0]]) begin
								phase_d = phase_q + PH_W'(1);
								cnt_d   = '0;
								level_d = ~phase_q[0];
							end
						end
						default: begin
							kind_d  = KIND_IDLE;
							phase_d = '0;
							cnt_d   = '0;
							level_d = 1'b0;
						end
					endcase
				end
			end
			MODE_BEEPS: begin
				if (kind_q == KIND_IDLE) begin
					beeps_d = item.repeat_count;
					on_d    = item.beep_on_ms;
					off_d   = item.beep_off_ms;
					kind_d  = KIND_BEEPS;
					phase_d = '0;
					cnt_d   = '0;
				end
			end
			MODE_PATTERN: begin
				if (kind_q == KIND_IDLE) begin
					seg_load = 1'b1;
					kind_d   = KIND_PATTERN;
					phase_d  = '0;
					cnt_d    = '0;
				end
			end
			MODE_LEVEL: level_d = item.drive_level;
			default: ;
		endcase
	end

	assign res.buzzer_on = level_d;
	assign res.busy_res  = (kind_d != KIND_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_IDLE;
			phase_q <= '0;
			cnt_q   <= '0;
			beeps_q <= '0;
			on_q    <= '0;
			off_q   <= '0;
			level_q <= 1'b0;
			for (int i = 0; i < PATTERN_SEGMENTS; i++)
				seg_q[i] <= '0;
		end else if (step) begin
			kind_q  <= kind_d;
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			beeps_q <= beeps_d;
			on_q    <= on_d;
			off_q   <= off_d;
			level_q <= level_d;
			if (seg_load) begin
				for (int i = 0; i < PATTERN_SEGMENTS; i++)
					seg_q[i] <= load_seg[i];
			end
		end
	end

	// idle always parks phase and counter at zero
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		kind_q == KIND_IDLE |-> phase_q == '0 && cnt_q == '0)
		else $error("idle with nonzero phase or counter");

	// beep mode never leaves its three phases
	a_beep_phase: assert property (@(posedge clk) disable iff (!arst_n)
		kind_q == KIND_BEEPS |-> phase_q <= PH_W'(2))
		else $error("beep phase out of range");

	// a tick while idle changes nothing
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.mode == MODE_TICK && kind_q == KIND_IDLE
		|=> kind_q == KIND_IDLE && $stable(level_q))
		else $error("tick while idle changed state");

	// a start while busy is dropped
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		step && kind_q != KIND_IDLE && (item.mode == MODE_BEEPS || item.mode == MODE_PATTERN)
		|=> $stable(kind_q) && $stable(beeps_q) && $stable(phase_q))
		else $error("start accepted while busy");

	// state holds between transactions
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(kind_q) && $stable(cnt_q) && $stable(level_q))
		else $error("state moved without a transaction");

endmodule

>>> hdl/buzzer_beep_pattern_sequencer_top.sv
// Top level: input stage, sequencer core and result register.
// Timing: an accepted command is held in the input stage until the result register has
// room; its result then loads into the result register, which raises rsp_valid.
// Throughput: one command per cycle from the combinational next-state update; input
// stalls only while the stage holds a command and a result waits with rsp_ready low.
// Reset: arst_n idles the sequencer, silences the buzzer and empties both registers.
module buzzer_beep_pattern_sequencer_top import bbps_pkg::*; #(
	parameter int PATTERN_SEGMENTS = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// Input stage: one command held here until the result register has room.
	logic valid_s1;
	cmd_t cmd_s1;

	// Result register: decouples the downstream stall from the input side.
	logic rsp_valid_q;
	rsp_t rsp_q;

	// Core result for the command in the input stage.
	rsp_t core_res;

	// adv: the command in the input stage is executed this cycle. It updates
	// the sequencer state and its result lands in the result register.
	logic adv;

	assign adv       = valid_s1 && (!rsp_valid_q || rsp_ready);
	// A new transaction is taken while the stage is empty or draining, so a
	// waiting result blocks the input only once the stage is occupied too.
	assign cmd_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready)
			cmd_s1 <= cmd;
	end

	// Sequencer: all state updates happen here, one command per adv pulse,
	// in acceptance order.
	bbps_core #(
		.PATTERN_SEGMENTS(PATTERN_SEGMENTS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (adv),
		.item  (cmd_s1),
		.res   (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			rsp_q <= core_res;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
